// ----- design/pdc_pkg.sv -----
// shared types and constants for the deadband pid controller
package pdc_pkg;

    // fixed field widths
    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 32;
    localparam int LIM_W     = 31;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_W    = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX   = 3'd6;

    // register reset values
    localparam logic signed [GAIN_W-1:0] GAIN_P_RST    = 32'sd55706;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST    = 32'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST    = 32'sd0;
    localparam logic [LIM_W-1:0]         DEADBAND_RST  = 31'd1311;
    localparam logic [LIM_W-1:0]         INT_LIMIT_RST = 31'd32768;
    localparam logic signed [DATA_W-1:0] OUT_MIN_RST   = -32'sd655294464;
    localparam logic signed [DATA_W-1:0] OUT_MAX_RST   = 32'sd655294464;

    // configuration as seen by the datapath
    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [LIM_W-1:0]         deadband;
        logic [LIM_W-1:0]         integral_limit;
        logic signed [DATA_W-1:0] out_min;
        logic signed [DATA_W-1:0] out_max;
    } cfg_t;

    // per-stage load strobes
    typedef struct packed {
        logic ld_in;
        logic ld_err;
        logic ld_state;
        logic ld_prod;
        logic ld_out;
    } pipe_ld_t;

endpackage

// ----- design/pdc_cfg_regs.sv -----
// configuration register file for the deadband pid controller
module pdc_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pdc_pkg::DATA_W-1:0]     cfg_data,
    output pdc_pkg::cfg_t                  cfg
);
    import pdc_pkg::*;

    cfg_t cfg_reg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= GAIN_P_RST;
            cfg_reg.gain_i         <= GAIN_I_RST;
            cfg_reg.gain_d         <= GAIN_D_RST;
            cfg_reg.deadband       <= DEADBAND_RST;
            cfg_reg.integral_limit <= INT_LIMIT_RST;
            cfg_reg.out_min        <= OUT_MIN_RST;
            cfg_reg.out_max        <= OUT_MAX_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_GAIN_P:    cfg_reg.gain_p         <= cfg_data;
                REG_GAIN_I:    cfg_reg.gain_i         <= cfg_data;
                REG_GAIN_D:    cfg_reg.gain_d         <= cfg_data;
                REG_DEADBAND:  cfg_reg.deadband       <= cfg_data[LIM_W-1:0];
                REG_INT_LIMIT: cfg_reg.integral_limit <= cfg_data[LIM_W-1:0];
                REG_OUT_MIN:   cfg_reg.out_min        <= cfg_data;
                REG_OUT_MAX:   cfg_reg.out_max        <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/pdc_err_stage.sv -----
// input register, error with deadband, and integral and derivative state
module pdc_err_stage
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pdc_pkg::pipe_ld_t                     ld,
    input  pdc_pkg::cfg_t                         cfg,
    input  logic signed [pdc_pkg::DATA_W-1:0]     target,
    input  logic signed [pdc_pkg::DATA_W-1:0]     measured,
    output logic signed [VALUE_WIDTH-1:0]         err,
    output logic signed [VALUE_WIDTH-1:0]         err_sum,
    output logic signed [VALUE_WIDTH:0]           deriv
);
    import pdc_pkg::*;

    // working width holds any difference, sum or limit without overflow
    localparam int XW = ((VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W) + 2;
    localparam logic signed [XW-1:0] V_MAX =
        {{(XW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [XW-1:0] V_MIN =
        {{(XW-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};

    function automatic logic signed [VALUE_WIDTH-1:0] sat_vw(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        begin
            if (v > V_MAX)
                r = V_MAX;
            else if (v < V_MIN)
                r = V_MIN;
            else
                r = v;
            return r[VALUE_WIDTH-1:0];
        end
    endfunction

    logic signed [DATA_W-1:0]      target_reg;
    logic signed [DATA_W-1:0]      measured_reg;
    logic signed [VALUE_WIDTH-1:0] err_reg;
    logic signed [VALUE_WIDTH-1:0] err_next;
    logic signed [VALUE_WIDTH-1:0] err_st_reg;
    logic signed [VALUE_WIDTH-1:0] prev_err_reg;
    logic signed [VALUE_WIDTH-1:0] err_sum_reg;
    logic signed [VALUE_WIDTH-1:0] err_sum_next;
    logic signed [VALUE_WIDTH:0]   deriv_reg;
    logic signed [VALUE_WIDTH:0]   deriv_next;

    logic signed [XW-1:0] diff;
    logic signed [XW-1:0] err_x;
    logic signed [XW-1:0] band_x;
    logic signed [XW-1:0] lim_x;
    logic signed [XW-1:0] sum_raw;
    logic signed [XW-1:0] sum_clamped;
    logic signed [VALUE_WIDTH-1:0] err_sat;

    // input word register
    always_ff @(posedge clk)
    begin
        if (ld.ld_in)
        begin
            target_reg   <= target;
            measured_reg <= measured;
        end
    end

    // saturated error, zeroed inside the deadband
    always_comb
    begin
        diff     = XW'(target_reg) - XW'(measured_reg);
        err_sat  = sat_vw(diff);
        err_x    = XW'(err_sat);
        band_x   = $signed(XW'(cfg.deadband));
        err_next = ((err_x < band_x) && (err_x > -band_x)) ? '0 : err_sat;
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld_err)
            err_reg <= err_next;
    end

    // derivative and clamped running sum
    always_comb
    begin
        deriv_next = (VALUE_WIDTH+1)'(err_reg) - (VALUE_WIDTH+1)'(prev_err_reg);
        sum_raw    = XW'(err_sum_reg) + XW'(err_reg);
        lim_x      = $signed(XW'(cfg.integral_limit));
        if (sum_raw < -lim_x)
            sum_clamped = -lim_x;
        else if (sum_raw > lim_x)
            sum_clamped = lim_x;
        else
            sum_clamped = sum_raw;
        err_sum_next = sat_vw(sum_clamped);
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            err_sum_reg  <= '0;
        end
        else if (ld.ld_state)
        begin
            prev_err_reg <= err_reg;
            err_sum_reg  <= err_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld_state)
        begin
            err_st_reg <= err_reg;
            deriv_reg  <= deriv_next;
        end
    end

    assign err     = err_st_reg;
    assign err_sum = err_sum_reg;
    assign deriv   = deriv_reg;

endmodule

// ----- design/pdc_mac_stage.sv -----
// gain products, wide sum and output clamp
module pdc_mac_stage
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                                  clk,
    input  pdc_pkg::pipe_ld_t                     ld,
    input  pdc_pkg::cfg_t                         cfg,
    input  logic signed [VALUE_WIDTH-1:0]         err,
    input  logic signed [VALUE_WIDTH-1:0]         err_sum,
    input  logic signed [VALUE_WIDTH:0]           deriv,
    output logic signed [pdc_pkg::DATA_W-1:0]     drive
);
    import pdc_pkg::*;

    localparam int PW = VALUE_WIDTH + GAIN_W;
    localparam int TW = PW - FRAC_W;
    localparam int SW = VALUE_WIDTH + FRAC_W + 3;

    logic signed [PW-1:0]     prod_p;
    logic signed [PW-1:0]     prod_i;
    logic signed [PW:0]       prod_d;
    logic signed [TW-1:0]     term_p_reg;
    logic signed [TW-1:0]     term_i_reg;
    logic signed [TW:0]       term_d_reg;
    logic signed [SW-1:0]     total;
    logic signed [SW-1:0]     min_x;
    logic signed [SW-1:0]     max_x;
    logic signed [DATA_W-1:0] drive_next;
    logic signed [DATA_W-1:0] drive_reg;

    // three products, each floored to the fraction point
    assign prod_p = PW'(err) * PW'(cfg.gain_p);
    assign prod_i = PW'(err_sum) * PW'(cfg.gain_i);
    assign prod_d = (PW+1)'(deriv) * (PW+1)'(cfg.gain_d);

    always_ff @(posedge clk)
    begin
        if (ld.ld_prod)
        begin
            term_p_reg <= prod_p[PW-1:FRAC_W];
            term_i_reg <= prod_i[PW-1:FRAC_W];
            term_d_reg <= prod_d[PW:FRAC_W];
        end
    end

    // exact sum then clamp, lower bound checked first
    always_comb
    begin
        total = SW'(term_p_reg) + SW'(term_i_reg) + SW'(term_d_reg);
        min_x = SW'(cfg.out_min);
        max_x = SW'(cfg.out_max);
        if (total < min_x)
            drive_next = cfg.out_min;
        else if (total > max_x)
            drive_next = cfg.out_max;
        else
            drive_next = total[DATA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld_out)
            drive_reg <= drive_next;
    end

    assign drive = drive_reg;

endmodule

// ----- design/pid_deadband_clamped_top.sv -----
// top level of the deadband pid controller with integral clamp
//
// input channel: in_valid/in_ready carry a target and measured word, signed q16.16.
// output channel: out_valid/out_ready carry one drive word per input word.
// configuration: cfg_wr_en writes cfg_data to the register at cfg_index (gains,
// deadband, integral limit, output limits); write only while idle.
// the datapath is five register stages: input, error, state, products, output.
// one word is taken every cycle while the receiver keeps taking drive words,
// set by the single pass through the three gain multipliers.
// the integral sum and previous error update in the state stage, in order.
// when the receiver stalls, stages fill bubble by bubble and in_ready drops
// only once all five stages hold a word; the drive word holds until taken.
// reset empties the pipeline, clears the sum and previous error and loads
// the register defaults.
module pid_deadband_clamped_top
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pdc_pkg::DATA_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pdc_pkg::DATA_W-1:0]     target,
    input  logic signed [pdc_pkg::DATA_W-1:0]     measured,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pdc_pkg::DATA_W-1:0]     drive
);
    import pdc_pkg::*;

    cfg_t     cfg;
    pipe_ld_t ld;

    logic v_in_reg;
    logic v_err_reg;
    logic v_st_reg;
    logic v_prod_reg;
    logic v_out_reg;
    logic adv_in;
    logic adv_err;
    logic adv_st;
    logic adv_prod;
    logic adv_out;

    logic signed [VALUE_WIDTH-1:0] err;
    logic signed [VALUE_WIDTH-1:0] err_sum;
    logic signed [VALUE_WIDTH:0]   deriv;

    // a stage moves when it is empty or its successor moves
    always_comb
    begin
        adv_out     = !v_out_reg || out_ready;
        adv_prod    = !v_prod_reg || adv_out;
        adv_st      = !v_st_reg || adv_prod;
        adv_err     = !v_err_reg || adv_st;
        adv_in      = !v_in_reg || adv_err;
        ld.ld_in    = adv_in && in_valid;
        ld.ld_err   = adv_err && v_in_reg;
        ld.ld_state = adv_st && v_err_reg;
        ld.ld_prod  = adv_prod && v_st_reg;
        ld.ld_out   = adv_out && v_prod_reg;
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg   <= 1'b0;
            v_err_reg  <= 1'b0;
            v_st_reg   <= 1'b0;
            v_prod_reg <= 1'b0;
            v_out_reg  <= 1'b0;
        end
        else
        begin
            if (adv_in)
                v_in_reg <= in_valid;
            if (adv_err)
                v_err_reg <= v_in_reg;
            if (adv_st)
                v_st_reg <= v_err_reg;
            if (adv_prod)
                v_prod_reg <= v_st_reg;
            if (adv_out)
                v_out_reg <= v_prod_reg;
        end
    end

    assign in_ready  = adv_in;
    assign out_valid = v_out_reg;

    pdc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdc_err_stage #(.VALUE_WIDTH(VALUE_WIDTH)) u_err
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld       (ld),
        .cfg      (cfg),
        .target   (target),
        .measured (measured),
        .err      (err),
        .err_sum  (err_sum),
        .deriv    (deriv)
    );

    pdc_mac_stage #(.VALUE_WIDTH(VALUE_WIDTH)) u_mac
    (
        .clk     (clk),
        .ld      (ld),
        .cfg     (cfg),
        .err     (err),
        .err_sum (err_sum),
        .deriv   (deriv),
        .drive   (drive)
    );

    // input held off only when every stage is full and the output stalls
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v_in_reg && v_err_reg && v_st_reg && v_prod_reg && v_out_reg
                       && !out_ready))
        else $error("input blocked while pipeline has room");

    // a stalled drive word is neither lost nor altered
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v_out_reg && !out_ready) |=> (v_out_reg && $stable(drive)))
        else $error("stalled drive word changed");

    // a word entering an empty pipeline comes out valid after the input, error, state, products and output stages
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !v_in_reg && !v_err_reg && !v_st_reg
         && !v_prod_reg && !v_out_reg) |-> ##5 out_valid)
        else $error("drive word missing after pipeline latency");

endmodule

// ----- tb/sv/pid_drive_checker.sv -----
// drive word predictor and scoreboard for the deadband pid controller
module pid_drive_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdc_pkg::DATA_W-1:0]        cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic signed [pdc_pkg::DATA_W-1:0] target,
    input  logic signed [pdc_pkg::DATA_W-1:0] measured,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [pdc_pkg::DATA_W-1:0] drive,
    output int                                mismatch_count,
    output int                                words_waiting,
    output int                                words_checked
);
    import pdc_pkg::*;

    localparam int     REPORT_MAX = 10;
    localparam longint ERR_MAX    = 64'sd2147483647;
    localparam longint ERR_MIN    = -64'sd2147483648;

    // register copy and loop state as the block should hold them
    cfg_t                     loop_cfg;
    logic signed [DATA_W-1:0] last_error;
    logic signed [DATA_W-1:0] error_total;

    // predicted drive words, oldest first
    logic signed [DATA_W-1:0] drive_expected[$];

    int fail_total = 0;
    int drive_ok   = 0;

    always @(posedge clk or negedge rst_n)
    begin : track
        longint                   err;
        longint                   slope;
        longint                   acc;
        longint                   band;
        longint                   lim;
        logic signed [79:0]       wide;
        logic signed [79:0]       total;
        logic signed [DATA_W-1:0] want;
        if (!rst_n)
        begin
            loop_cfg.gain_p         = GAIN_P_RST;
            loop_cfg.gain_i         = GAIN_I_RST;
            loop_cfg.gain_d         = GAIN_D_RST;
            loop_cfg.deadband       = DEADBAND_RST;
            loop_cfg.integral_limit = INT_LIMIT_RST;
            loop_cfg.out_min        = OUT_MIN_RST;
            loop_cfg.out_max        = OUT_MAX_RST;
            last_error              = '0;
            error_total             = '0;
            drive_expected.delete();
        end
        else
        begin
            // register writes, an unknown index changes nothing
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_GAIN_P:    loop_cfg.gain_p = cfg_data;
                    REG_GAIN_I:    loop_cfg.gain_i = cfg_data;
                    REG_GAIN_D:    loop_cfg.gain_d = cfg_data;
                    REG_DEADBAND:  loop_cfg.deadband = cfg_data[LIM_W-1:0];
                    REG_INT_LIMIT: loop_cfg.integral_limit = cfg_data[LIM_W-1:0];
                    REG_OUT_MIN:   loop_cfg.out_min = cfg_data;
                    REG_OUT_MAX:   loop_cfg.out_max = cfg_data;
                    default:       ;
                endcase
            end

            // drive word taken from the block
            if (out_valid && out_ready)
            begin
                if (drive_expected.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= REPORT_MAX)
                        $display("drive word %0d with nothing expected", drive);
                end
                else
                begin
                    want = drive_expected.pop_front();
                    if (drive !== want)
                    begin
                        fail_total++;
                        if (fail_total <= REPORT_MAX)
                            $display("drive mismatch: expected %0d, got %0d", want, drive);
                    end
                    else
                        drive_ok++;
                end
            end

            // word accepted: saturated error, deadband, derivative
            if (in_valid && in_ready)
            begin
                err = target;
                err = err - measured;
                if (err > ERR_MAX)
                    err = ERR_MAX;
                else if (err < ERR_MIN)
                    err = ERR_MIN;
                band = longint'(loop_cfg.deadband);
                if (err < band && err > -band)
                    err = 0;
                slope = err - longint'(last_error);

                // integral with symmetric clamp, the limit keeps it inside 32 bits
                lim = longint'(loop_cfg.integral_limit);
                acc = longint'(error_total) + err;
                if (acc < -lim)
                    acc = -lim;
                else if (acc > lim)
                    acc = lim;

                // exact products, each floored by the fraction width, summed wide
                wide  = err;
                total = (wide * $signed(loop_cfg.gain_p)) >>> FRAC_W;
                wide  = acc;
                total = total + ((wide * $signed(loop_cfg.gain_i)) >>> FRAC_W);
                wide  = slope;
                total = total + ((wide * $signed(loop_cfg.gain_d)) >>> FRAC_W);

                // lower bound wins when the limits cross
                if (total < $signed(loop_cfg.out_min))
                    want = loop_cfg.out_min;
                else if (total > $signed(loop_cfg.out_max))
                    want = loop_cfg.out_max;
                else
                    want = total[DATA_W-1:0];
                drive_expected.push_back(want);

                last_error  = err[DATA_W-1:0];
                error_total = acc[DATA_W-1:0];
            end
        end
        mismatch_count <= fail_total;
        words_waiting  <= drive_expected.size();
        words_checked  <= drive_ok;
    end

endmodule

// ----- tb/sv/pid_deadband_clamped_top_test.sv -----
// testbench top for the deadband pid controller: stimulus, settings and verdict
module pid_deadband_clamped_top_test;

    import pdc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int QUIET_LIMIT   = 5000;
    localparam int PHASE_WORDS   = 182;
    localparam int RANDOM_PHASES = 8;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [DATA_W-1:0]        cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic signed [DATA_W-1:0] target    = '0;
    logic signed [DATA_W-1:0] measured  = '0;
    logic                     out_ready = 1'b0;
    logic                     in_ready;
    logic                     out_valid;
    logic signed [DATA_W-1:0] drive;

    int mismatch_count;
    int words_waiting;
    int words_checked;
    bit idle_on       = 1'b1;
    int quiet_cycles  = 0;
    int words_sent    = 0;
    int settings_used = 1;

    pid_deadband_clamped_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .target    (target),
        .measured  (measured),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive)
    );

    pid_drive_checker watch
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .target         (target),
        .measured       (measured),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive          (drive),
        .mismatch_count (mismatch_count),
        .words_waiting  (words_waiting),
        .words_checked  (words_checked)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver stalls
    always @(posedge clk)
        out_ready <= idle_on ? ($urandom_range(99) >= 24) : 1'b1;

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // one input word, with random gaps ahead of it while idling is on
    task automatic send_word(input logic signed [DATA_W-1:0] t, input logic signed [DATA_W-1:0] m);
        while (idle_on && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        target   <= t;
        measured <= m;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // stop sending and wait for every drive word to come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_waiting != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // full register set, optionally followed by a write to the unused index
    task automatic load_settings(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
                                 input logic [DATA_W-1:0] kd, input logic [DATA_W-1:0] band,
                                 input logic [DATA_W-1:0] lim, input logic [DATA_W-1:0] lo,
                                 input logic [DATA_W-1:0] hi, input bit spare);
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_GAIN_D, kd);
        write_reg(REG_DEADBAND, band);
        write_reg(REG_INT_LIMIT, lim);
        write_reg(REG_OUT_MIN, lo);
        write_reg(REG_OUT_MAX, hi);
        if (spare)
            write_reg(REG_SPARE, $urandom);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [DATA_W-1:0] any_gain();
        case ($urandom_range(5))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3, 4:    return $urandom_range(1 << 19) - (1 << 18);
            default: return $urandom;
        endcase
    endfunction

    // 31-bit magnitude, top bit of the bus random as the block drops it
    function automatic logic [DATA_W-1:0] any_limit();
        logic [LIM_W-1:0] mag;
        case ($urandom_range(4))
            0:       mag = '0;
            1:       mag = '1;
            2, 3:    mag = LIM_W'($urandom_range(1 << 14));
            default: mag = LIM_W'($urandom);
        endcase
        return {1'($urandom_range(1)), mag};
    endfunction

    function automatic logic signed [DATA_W-1:0] any_value();
        case ($urandom_range(9))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return '1;
            4, 5:    return $urandom;
            default: return $urandom_range(1 << 25) - (1 << 24);
        endcase
    endfunction

    initial
    begin : stimulus
        logic signed [DATA_W-1:0] t;
        logic signed [DATA_W-1:0] m;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic signed [DATA_W-1:0] swap;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: deadband edges on both sides, error overflow, extremes
        send_word(32'sd1311, 32'sd0);
        send_word(32'sd1310, 32'sd0);
        send_word(32'sd0, 32'sd1310);
        send_word(32'sd0, 32'sd1311);
        send_word(WORD_MAX, WORD_MIN);
        send_word(WORD_MIN, WORD_MAX);
        send_word(WORD_MAX, WORD_MAX);
        send_word(WORD_MIN, WORD_MIN);
        send_word('1, 32'sd0);
        send_word(32'sd0, 32'sd0);
        settle();

        // extreme gains, zero deadband, widest integral and output range
        load_settings(WORD_MAX, WORD_MIN, WORD_MAX, '0, 32'h7FFF_FFFF, WORD_MIN, WORD_MAX, 1'b1);
        send_word(32'sd1, 32'sd0);
        send_word(32'sd0, 32'sd1);
        repeat (3) send_word(WORD_MAX, WORD_MIN);
        repeat (3) send_word(WORD_MIN, WORD_MAX);
        send_word(32'sd0, 32'sd0);
        send_word('1, 32'sd0);
        settle();

        // crossed output limits
        load_settings(32'sd65536, 32'sd32768, 32'sd16384, 32'd100, 32'd1 << 20,
                      32'sd1000 <<< 16, -(32'sd1000 <<< 16), 1'b0);
        send_word(WORD_MAX, WORD_MIN);
        send_word(32'sd0, 32'sd0);
        send_word(WORD_MIN, WORD_MAX);
        settle();

        // random settings, one phase with no idling on either side
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            lo = any_value();
            hi = any_value();
            if ($urandom_range(9) != 0 && lo > hi)
            begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end
            idle_on = (ph != 4);
            load_settings(any_gain(), any_gain(), any_gain(), any_limit(), any_limit(),
                          lo, hi, ph % 3 == 0);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                t = any_value();
                if ($urandom_range(9) < 6)
                    m = t + $urandom_range(1 << 16) - (1 << 15);
                else
                    m = any_value();
                send_word(t, m);
            end
            settle();
        end

        repeat (10) @(posedge clk);
        $display("%0d input words over %0d register settings, %0d drive words matched",
                 words_sent, settings_used, words_checked);
        $display("included deadband edges, error and integral saturation, crossed limits");
        if (mismatch_count == 0 && words_waiting == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- pid_deadband_clamped_top.f -----
design/pdc_pkg.sv
design/pdc_cfg_regs.sv
design/pdc_err_stage.sv
design/pdc_mac_stage.sv
design/pid_deadband_clamped_top.sv
tb/sv/pid_drive_checker.sv
tb/sv/pid_deadband_clamped_top_test.sv
